@@ rtl/mlrr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mlrr_pkg;

    localparam int LEVELS_DEF       = 4;
    localparam int SLOTS_DEF        = 16;
    localparam int CONTEXT_BITS_DEF = 32;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SCHED = 1'b1;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_DEAD    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_DONE
    } state_t;

    // memory port controls from the sequencer to the entry store
    typedef struct packed {
        logic st_we;
        logic ctx_we;
        logic rd_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mlrr_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mlrr_store import mlrr_pkg::*; #(
    parameter int AW           = 6,
    parameter int CONTEXT_BITS = CONTEXT_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire mem_ctl_t                ctl,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire status_t                 st_wdata,
    input  wire logic [CONTEXT_BITS-1:0] ctx_wdata,
    input  wire logic [AW-1:0]           rd_addr,
    output status_t                      rd_status,
    output logic [CONTEXT_BITS-1:0]      rd_ctx
);

    localparam int DEPTH = 2 ** AW;

    status_t                 status_mem [DEPTH];
    logic [CONTEXT_BITS-1:0] ctx_mem    [DEPTH];

    status_t                 rd_status_reg;
    logic [CONTEXT_BITS-1:0] rd_ctx_reg;

    // the scan never reads the entry it writes in the same cycle
    always_ff @(posedge clk)
    begin
        if (ctl.st_we)
        begin
            status_mem[wr_addr] <= st_wdata;
        end
        if (ctl.ctx_we)
        begin
            ctx_mem[wr_addr] <= ctx_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_status_reg <= status_mem[rd_addr];
            rd_ctx_reg    <= ctx_mem[rd_addr];
        end
    end

    assign rd_status = rd_status_reg;
    assign rd_ctx    = rd_ctx_reg;

endmodule

`default_nettype wire

@@ rtl/mlrr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mlrr_ctrl import mlrr_pkg::*; #(
    parameter int LEVELS       = LEVELS_DEF,
    parameter int SLOTS        = SLOTS_DEF,
    parameter int CONTEXT_BITS = CONTEXT_BITS_DEF,
    parameter int LW           = 2,
    parameter int SW           = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    req_type,
    input  wire logic [LW-1:0]           level,
    input  wire logic [SW-1:0]           slot,
    input  wire logic [1:0]              new_status,
    input  wire logic [CONTEXT_BITS-1:0] context_handle,
    output mem_ctl_t                     mem_ctl,
    output logic [LW+SW-1:0]             wr_addr,
    output status_t                      st_wdata,
    output logic [CONTEXT_BITS-1:0]      ctx_wdata,
    output logic [LW+SW-1:0]             rd_addr,
    input  wire status_t                 rd_status,
    input  wire logic [CONTEXT_BITS-1:0] rd_ctx,
    output logic                         res_valid,
    input  wire logic                    res_take,
    output logic                         res_found,
    output logic [LW-1:0]                res_level,
    output logic [SW-1:0]                res_slot,
    output logic [CONTEXT_BITS-1:0]      res_context
);

    localparam int          AW       = LW + SW;
    localparam int          DEPTH    = 2 ** AW;
    localparam logic [SW:0] SLOTS_C  = (SW + 1)'(SLOTS);
    localparam logic [LW:0] LEVELS_C = (LW + 1)'(LEVELS);
    localparam logic [LW-1:0] LAST_LV = LW'(LEVELS - 1);

    state_t state_reg, state_next;

    logic [AW-1:0] clr_reg, clr_next;

    // issue side of the scan: next entry to read
    logic [LW-1:0] iss_lv_reg, iss_lv_next;
    logic [SW:0]   iss_s_reg, iss_s_next;
    logic          iss_done_reg, iss_done_next;

    // evaluate side: entry whose read data arrives this cycle
    logic          pend_reg, pend_next;
    logic [LW-1:0] ev_lv_reg, ev_lv_next;
    logic [SW-1:0] ev_s_reg, ev_s_next;

    logic [SW:0]   ptr_reg  [LEVELS];
    logic [SW:0]   ptr_next [LEVELS];

    logic          run_valid_reg, run_valid_next;
    logic [LW-1:0] run_lv_reg, run_lv_next;
    logic [SW-1:0] run_s_reg, run_s_next;

    logic                    res_found_reg, res_found_next;
    logic [LW-1:0]           res_lv_reg, res_lv_next;
    logic [SW-1:0]           res_s_reg, res_s_next;
    logic [CONTEXT_BITS-1:0] res_ctx_reg, res_ctx_next;

    logic accept;
    logic hit;
    logic scan_end;
    logic in_range;
    logic [LW-1:0] lv_inc;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign hit      = pend_reg && (rd_status == ST_READY);
    assign scan_end = !pend_reg && iss_done_reg;
    assign in_range = ({1'b0, level} < LEVELS_C) && ({1'b0, slot} < SLOTS_C);
    assign lv_inc   = iss_lv_reg + LW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_SCHED) ? S_START : S_DONE;
                end
            end
            S_START:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit || scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        mem_ctl        = '0;
        wr_addr        = '0;
        st_wdata       = ST_EMPTY;
        ctx_wdata      = context_handle;
        rd_addr        = {iss_lv_reg, iss_s_reg[SW-1:0]};
        clr_next       = clr_reg;
        iss_lv_next    = iss_lv_reg;
        iss_s_next     = iss_s_reg;
        iss_done_next  = iss_done_reg;
        pend_next      = 1'b0;
        ev_lv_next     = ev_lv_reg;
        ev_s_next      = ev_s_reg;
        run_valid_next = run_valid_reg;
        run_lv_next    = run_lv_reg;
        run_s_next     = run_s_reg;
        res_found_next = res_found_reg;
        res_lv_next    = res_lv_reg;
        res_s_next     = res_s_reg;
        res_ctx_next   = res_ctx_reg;
        for (int l = 0; l < LEVELS; l++)
        begin
            ptr_next[l] = ptr_reg[l];
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.st_we = 1'b1;
                wr_addr       = clr_reg;
                clr_next      = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_found_next = 1'b0;
                    res_lv_next    = '0;
                    res_s_next     = '0;
                    res_ctx_next   = '0;
                    if (req_type == REQ_WRITE)
                    begin
                        mem_ctl.st_we  = in_range;
                        mem_ctl.ctx_we = in_range;
                        wr_addr        = {level, slot};
                        st_wdata       = status_t'(new_status);
                    end
                    else if (run_valid_reg)
                    begin
                        // save the preempted entry and resume its level after it
                        mem_ctl.st_we  = 1'b1;
                        mem_ctl.ctx_we = 1'b1;
                        wr_addr        = {run_lv_reg, run_s_reg};
                        st_wdata       = ST_READY;
                        ptr_next[run_lv_reg] = {1'b0, run_s_reg} + (SW + 1)'(1);
                    end
                end
            end
            S_START:
            begin
                iss_lv_next   = '0;
                iss_s_next    = ptr_reg[0];
                iss_done_next = 1'b0;
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    wr_addr = {ev_lv_reg, ev_s_reg};
                    if (rd_status == ST_DEAD)
                    begin
                        mem_ctl.st_we = 1'b1;
                        st_wdata      = ST_EMPTY;
                    end
                    else if (rd_status == ST_READY)
                    begin
                        mem_ctl.st_we  = 1'b1;
                        st_wdata       = ST_RUNNING;
                        run_valid_next = 1'b1;
                        run_lv_next    = ev_lv_reg;
                        run_s_next     = ev_s_reg;
                        res_found_next = 1'b1;
                        res_lv_next    = ev_lv_reg;
                        res_s_next     = ev_s_reg;
                        res_ctx_next   = rd_ctx;
                        // every level above the chosen one came up empty
                        for (int l = 0; l < LEVELS; l++)
                        begin
                            if ((LW + 1)'(l) < {1'b0, ev_lv_reg})
                            begin
                                ptr_next[l] = '0;
                            end
                        end
                    end
                end
                else if (iss_done_reg)
                begin
                    run_valid_next = 1'b0;
                    for (int l = 0; l < LEVELS; l++)
                    begin
                        ptr_next[l] = '0;
                    end
                end

                if (!hit && !iss_done_reg)
                begin
                    if (iss_s_reg < SLOTS_C)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        pend_next     = 1'b1;
                        ev_lv_next    = iss_lv_reg;
                        ev_s_next     = iss_s_reg[SW-1:0];
                        iss_s_next    = iss_s_reg + (SW + 1)'(1);
                    end
                    else if (iss_lv_reg == LAST_LV)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_lv_next = lv_inc;
                        iss_s_next  = ptr_reg[lv_inc];
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            iss_lv_reg    <= '0;
            iss_s_reg     <= '0;
            iss_done_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            run_valid_reg <= 1'b0;
            run_lv_reg    <= '0;
            run_s_reg     <= '0;
            for (int l = 0; l < LEVELS; l++)
            begin
                ptr_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            iss_lv_reg    <= iss_lv_next;
            iss_s_reg     <= iss_s_next;
            iss_done_reg  <= iss_done_next;
            pend_reg      <= pend_next;
            run_valid_reg <= run_valid_next;
            run_lv_reg    <= run_lv_next;
            run_s_reg     <= run_s_next;
            for (int l = 0; l < LEVELS; l++)
            begin
                ptr_reg[l] <= ptr_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ev_lv_reg     <= ev_lv_next;
        ev_s_reg      <= ev_s_next;
        res_found_reg <= res_found_next;
        res_lv_reg    <= res_lv_next;
        res_s_reg     <= res_s_next;
        res_ctx_reg   <= res_ctx_next;
    end

    assign res_valid   = (state_reg == S_DONE);
    assign res_found   = res_found_reg;
    assign res_level   = res_lv_reg;
    assign res_slot    = res_s_reg;
    assign res_context = res_ctx_reg;

endmodule

`default_nettype wire

@@ rtl/multilevel_round_robin_scheduler_top.sv @@
// Multilevel priority round-robin scheduler. Entry status and context handles live in two
// single-port-read synchronous memories addressed by {level, slot}; the sequencer visits one
// entry per cycle except while passing to the next level, so throughput is set by that one
// memory read port. After reset a clearing pass marks all 2**(LW+SW) entries empty, during
// which in_stall stays high. A write request goes straight to its result, with found low. A
// schedule request saves any preempted entry, then scans from level 0 up until it finds a
// ready entry or passes all levels. One request is in flight at a time; the result sits in
// an output register, so the next request can transfer while it waits.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_round_robin_scheduler_top import mlrr_pkg::*; #(
    parameter int LEVELS       = LEVELS_DEF,
    parameter int SLOTS        = SLOTS_DEF,
    parameter int CONTEXT_BITS = CONTEXT_BITS_DEF,
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1,
    localparam int SW = $clog2(SLOTS)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    req_type,
    input  wire logic [LW-1:0]           level,
    input  wire logic [SW-1:0]           slot,
    input  wire logic [1:0]              new_status,
    input  wire logic [CONTEXT_BITS-1:0] context_handle,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         found,
    output logic [LW-1:0]                next_level,
    output logic [SW-1:0]                next_slot,
    output logic [CONTEXT_BITS-1:0]      next_context
);

    localparam int AW = LW + SW;

    mem_ctl_t                mem_ctl;
    logic [AW-1:0]           wr_addr;
    status_t                 st_wdata;
    logic [CONTEXT_BITS-1:0] ctx_wdata;
    logic [AW-1:0]           rd_addr;
    status_t                 rd_status;
    logic [CONTEXT_BITS-1:0] rd_ctx;

    logic                    res_valid;
    logic                    res_take;
    logic                    res_found;
    logic [LW-1:0]           res_level;
    logic [SW-1:0]           res_slot;
    logic [CONTEXT_BITS-1:0] res_context;

    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg;
    logic [LW-1:0]           level_reg;
    logic [SW-1:0]           slot_reg;
    logic [CONTEXT_BITS-1:0] context_reg;

    mlrr_ctrl #(
        .LEVELS       (LEVELS),
        .SLOTS        (SLOTS),
        .CONTEXT_BITS (CONTEXT_BITS),
        .LW           (LW),
        .SW           (SW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .level          (level),
        .slot           (slot),
        .new_status     (new_status),
        .context_handle (context_handle),
        .mem_ctl        (mem_ctl),
        .wr_addr        (wr_addr),
        .st_wdata       (st_wdata),
        .ctx_wdata      (ctx_wdata),
        .rd_addr        (rd_addr),
        .rd_status      (rd_status),
        .rd_ctx         (rd_ctx),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res_found      (res_found),
        .res_level      (res_level),
        .res_slot       (res_slot),
        .res_context    (res_context)
    );

    mlrr_store #(
        .AW           (AW),
        .CONTEXT_BITS (CONTEXT_BITS)
    ) u_store (
        .clk       (clk),
        .ctl       (mem_ctl),
        .wr_addr   (wr_addr),
        .st_wdata  (st_wdata),
        .ctx_wdata (ctx_wdata),
        .rd_addr   (rd_addr),
        .rd_status (rd_status),
        .rd_ctx    (rd_ctx)
    );

    // load the output register when it is empty or its transfer completes now
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            found_reg   <= res_found;
            level_reg   <= res_level;
            slot_reg    <= res_slot;
            context_reg <= res_context;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign next_level   = level_reg;
    assign next_slot    = slot_reg;
    assign next_context = context_reg;

endmodule

`default_nettype wire

@@ tb/multilevel_round_robin_scheduler_top_tb.sv @@
`timescale 1ns / 1ps

module multilevel_round_robin_scheduler_top_tb;
    import mlrr_pkg::*;

    localparam int NLEV        = LEVELS_DEF;
    localparam int NSLOT       = SLOTS_DEF;
    localparam int CW          = CONTEXT_BITS_DEF;
    localparam int LW          = (NLEV > 1) ? $clog2(NLEV) : 1;
    localparam int SW          = $clog2(NSLOT);
    localparam int PHASE_ITEMS = 200;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic          kind;
        logic [LW-1:0] level;
        logic [SW-1:0] slot;
        logic [1:0]    status;
        logic [CW-1:0] ctx;
    } sched_req_t;

    typedef struct packed {
        logic          found;
        logic [LW-1:0] level;
        logic [SW-1:0] slot;
        logic [CW-1:0] ctx;
    } grant_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          req_type = REQ_WRITE;
    logic [LW-1:0] level = '0;
    logic [SW-1:0] slot = '0;
    logic [1:0]    new_status = ST_EMPTY;
    logic [CW-1:0] context_handle = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          found;
    logic [LW-1:0] next_level;
    logic [SW-1:0] next_slot;
    logic [CW-1:0] next_context;

    // scheduler image kept by the testbench
    status_t       entry_state [NLEV][NSLOT];
    logic [CW-1:0] entry_ctx [NLEV][NSLOT];
    int unsigned   resume_ptr [NLEV];
    int unsigned   run_level;
    int unsigned   run_slot;
    bit            run_valid;

    sched_req_t request_q[$];
    grant_t     grant_expect_q[$];
    sched_req_t drv_req;
    grant_t     mon_grant;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    logic hold_go = 1'b0;
    bit  hold_used = 1'b0;

    multilevel_round_robin_scheduler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .level          (level),
        .slot           (slot),
        .new_status     (new_status),
        .context_handle (context_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .next_level     (next_level),
        .next_slot      (next_slot),
        .next_context   (next_context)
    );

    always #4 clk = ~clk;

    function automatic grant_t predict_grant(input sched_req_t req);
        grant_t      g;
        int unsigned lv;
        int unsigned s;
        bit          hit;
        g = '0;
        hit = 1'b0;
        if (req.kind == REQ_WRITE)
        begin
            entry_state[req.level][req.slot] = status_t'(req.status);
            entry_ctx[req.level][req.slot] = req.ctx;
            return g;
        end
        // preempted entry takes the request's context and goes to the back of its level
        if (run_valid)
        begin
            entry_ctx[run_level][run_slot] = req.ctx;
            entry_state[run_level][run_slot] = ST_READY;
            resume_ptr[run_level] = run_slot + 1;
        end
        for (lv = 0; lv < NLEV && !hit; lv++)
        begin
            for (s = resume_ptr[lv]; s < NSLOT && !hit; s++)
            begin
                if (entry_state[lv][s] == ST_DEAD)
                    entry_state[lv][s] = ST_EMPTY;
                else if (entry_state[lv][s] == ST_READY)
                begin
                    hit = 1'b1;
                    g.level = LW'(lv);
                    g.slot = SW'(s);
                end
            end
            if (!hit)
                resume_ptr[lv] = 0;
        end
        if (hit)
        begin
            entry_state[g.level][g.slot] = ST_RUNNING;
            run_level = g.level;
            run_slot = g.slot;
            run_valid = 1'b1;
            g.found = 1'b1;
            g.ctx = entry_ctx[g.level][g.slot];
        end
        else
        begin
            run_valid = 1'b0;
        end
        return g;
    endfunction

    task automatic put_req(input logic kind, input int lvl, input int slt,
                           input status_t st, input logic [CW-1:0] ctx);
        sched_req_t r;
        r.kind = kind;
        r.level = LW'(lvl);
        r.slot = SW'(slt);
        r.status = st;
        r.ctx = ctx;
        request_q.push_back(r);
    endtask

    function automatic status_t pick_status();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return ST_READY;
        else if (r < 70)
            return ST_DEAD;
        else if (r < 85)
            return ST_EMPTY;
        return ST_RUNNING;
    endfunction

    // mostly populate-then-tick bursts, some loose noise items
    task automatic add_random_items(input int target);
        int added;
        int lv;
        int n;
        added = 0;
        while (added < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                lv = $urandom_range(NLEV - 1);
                n = $urandom_range(5, 1);
                repeat (n)
                begin
                    if ($urandom_range(3) == 0)
                        lv = $urandom_range(NLEV - 1);
                    put_req(REQ_WRITE, lv, $urandom_range(NSLOT - 1), pick_status(), $urandom);
                end
                added += n;
                n = $urandom_range(4, 1);
                repeat (n)
                    put_req(REQ_SCHED, $urandom_range(NLEV - 1), $urandom_range(NSLOT - 1),
                            status_t'($urandom_range(3)), $urandom);
                added += n;
            end
            else
            begin
                put_req(logic'($urandom_range(1)), $urandom_range(NLEV - 1),
                        $urandom_range(NSLOT - 1), status_t'($urandom_range(3)), $urandom);
                added++;
            end
        end
    endtask

    // sampled away from the rising edge so the driver and monitor have settled
    task automatic wait_drained();
        while (request_q.size() != 0 || in_valid || grant_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // driver: predicts on each input transfer, then offers the next request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                grant_expect_q.push_back(predict_grant({req_type, level, slot, new_status,
                                                        context_handle}));
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= drv_req.kind;
                    level <= drv_req.level;
                    slot <= drv_req.slot;
                    new_status <= drv_req.status;
                    context_handle <= drv_req.ctx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, so requests pile up behind the output register
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks each output transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (grant_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0h level=%0h slot=%0h ctx=%0h",
                             $time, found, next_level, next_slot, next_context);
                    mismatch_count++;
                end
                else
                begin
                    mon_grant = grant_expect_q.pop_front();
                    if (found !== mon_grant.found)
                    begin
                        $display("%0t: found expected %0h actual %0h",
                                 $time, mon_grant.found, found);
                        mismatch_count++;
                    end
                    if (next_level !== mon_grant.level)
                    begin
                        $display("%0t: next_level expected %0h actual %0h",
                                 $time, mon_grant.level, next_level);
                        mismatch_count++;
                    end
                    if (next_slot !== mon_grant.slot)
                    begin
                        $display("%0t: next_slot expected %0h actual %0h",
                                 $time, mon_grant.slot, next_slot);
                        mismatch_count++;
                    end
                    if (next_context !== mon_grant.ctx)
                    begin
                        $display("%0t: next_context expected %0h actual %0h",
                                 $time, mon_grant.ctx, next_context);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multilevel_round_robin_scheduler_top verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int lv = 0; lv < NLEV; lv++)
        begin
            resume_ptr[lv] = 0;
            for (int s = 0; s < NSLOT; s++)
            begin
                entry_state[lv][s] = ST_EMPTY;
                entry_ctx[lv][s] = '0;
            end
        end
        run_level = 0;
        run_slot = 0;
        run_valid = 1'b0;

        // tick with nothing ready, then extremes of level, slot and context
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h0);
        put_req(REQ_WRITE, 0, 0, ST_READY, 32'h0000_0000);
        put_req(REQ_WRITE, NLEV - 1, NSLOT - 1, ST_READY, 32'hFFFF_FFFF);
        put_req(REQ_WRITE, 0, 5, ST_DEAD, 32'hA5A5_A5A5);
        put_req(REQ_WRITE, 0, NSLOT - 1, ST_RUNNING, 32'h5A5A_5A5A);
        put_req(REQ_SCHED, NLEV - 1, NSLOT - 1, ST_DEAD, 32'hDEAD_BEEF);
        // dead entry cleared on the way, lower level picked
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h1111_1111);
        // running entry in the last slot leaves its pointer past the end
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h2222_2222);
        // write over the running entry, next tick still saves it
        put_req(REQ_WRITE, 0, 0, ST_EMPTY, 32'h0);
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h3333_3333);
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h0);
        put_req(REQ_WRITE, 2, 7, ST_READY, 32'h1234_5678);
        put_req(REQ_WRITE, 1, 3, ST_DEAD, 32'h8765_4321);
        put_req(REQ_WRITE, 0, 0, ST_DEAD, 32'hFFFF_0000);
        put_req(REQ_SCHED, 3, 15, ST_RUNNING, 32'h0000_FFFF);
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h4444_4444);
        put_req(REQ_WRITE, 2, 8, ST_READY, 32'h9999_9999);
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h5555_5555);
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h6666_6666);
        put_req(REQ_SCHED, 0, 0, ST_EMPTY, 32'h7777_7777);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // no idling, with one long receiver hold-off
        add_random_items(PHASE_ITEMS);
        @(posedge clk);
        hold_go <= 1'b1;
        wait_drained();

        send_idle_pct = 79;
        recv_stall_pct = 0;
        add_random_items(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 79;
        add_random_items(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 22;
        recv_stall_pct = 22;
        add_random_items(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("multilevel_round_robin_scheduler_top verification clean");
        else
            $display("multilevel_round_robin_scheduler_top verification failed");
        $finish;
    end

endmodule

@@ multilevel_round_robin_scheduler_top.f @@
rtl/mlrr_pkg.sv
rtl/mlrr_store.sv
rtl/mlrr_ctrl.sv
rtl/multilevel_round_robin_scheduler_top.sv
tb/multilevel_round_robin_scheduler_top_tb.sv
